[sv/chained_chunk_cache_directory_assert.svh]
// Assertion macros for the chained chunk cache directory.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef CHAINED_CHUNK_CACHE_DIRECTORY_ASSERT_SVH
`define CHAINED_CHUNK_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ccd_pkg.sv]
// Shared types, codes and constants of the chained chunk cache directory.
// Used by ccd_front, ccd_back and the top level; depends on nothing.
package ccd_pkg;

	localparam int ENT_W       = 12;
	localparam int CHUNK_COUNT = 2 ** ENT_W;

	// Request kinds
	localparam logic [1:0] FN_WRITE  = 2'd0;
	localparam logic [1:0] FN_FINISH = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;

	// Chunk kinds
	localparam logic [2:0] KD_PTR = 3'd0;
	localparam logic [2:0] KD_128 = 3'd1;
	localparam logic [2:0] KD_512 = 3'd2;
	localparam logic [2:0] KD_2K  = 3'd3;

	// Entry type codes, also used as open write modes
	localparam logic [2:0] TY_NONE   = 3'd0;
	localparam logic [2:0] TY_RANDOM = 3'd1;
	localparam logic [2:0] TY_SMALL  = 3'd2;
	localparam logic [2:0] TY_SINGLE = 3'd3;
	localparam logic [2:0] TY_BEGIN  = 3'd4;
	localparam logic [2:0] TY_MIDDLE = 3'd5;
	localparam logic [2:0] TY_END    = 3'd6;

	// Classified operations
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_WR_BAD = 4'd1;
	localparam logic [3:0] OP_WR_PTR = 4'd2;
	localparam logic [3:0] OP_WR_128 = 4'd3;
	localparam logic [3:0] OP_WR_512 = 4'd4;
	localparam logic [3:0] OP_WR_2K  = 4'd5;
	localparam logic [3:0] OP_FIN    = 4'd6;
	localparam logic [3:0] OP_RD_PTR = 4'd7;
	localparam logic [3:0] OP_RD_128 = 4'd8;
	localparam logic [3:0] OP_RD_512 = 4'd9;
	localparam logic [3:0] OP_RD_2K  = 4'd10;
	localparam logic [3:0] OP_RD_BAD = 4'd11;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  chunk_kind;
		logic [15:0] object_id;
		logic [11:0] size;
		logic [11:0] link_chunk;
		logic [11:0] chain_pos;
	} req_t;

	typedef struct packed {
		logic [22:0] address;
		logic [11:0] size_out;
		logic        ok;
	} rsp_t;

	// Classified command passed from the front to the back
	typedef struct packed {
		logic [3:0]       op;
		logic [15:0]      obj;
		logic [9:0]       size_sm;
		logic [11:0]      size_big;
		logic             size_nz;
		logic [ENT_W-1:0] chain;
		logic [11:0]      cidx;
	} cmd_t;

endpackage

[sv/ccd_front.sv]
// Front end: accepts request beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on ccd_pkg.
module ccd_front import ccd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic pop
);

	cmd_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	// Classify the request and clamp its size for both size classes.
	always_comb begin
		cls.obj      = req.object_id;
		cls.chain    = req.link_chunk;
		cls.cidx     = req.chain_pos;
		cls.size_nz  = (req.size != 12'd0);
		cls.size_sm  = (req.size > 12'd512) ? 10'd512 : req.size[9:0];
		cls.size_big = (req.size > 12'd2048) ? 12'd2048 : req.size;
		case (req.func)
			FN_WRITE: begin
				case (req.chunk_kind)
					KD_PTR:  cls.op = OP_WR_PTR;
					KD_128:  cls.op = OP_WR_128;
					KD_512:  cls.op = OP_WR_512;
					KD_2K:   cls.op = OP_WR_2K;
					default: cls.op = OP_WR_BAD;
				endcase
			end
			FN_FINISH: cls.op = OP_FIN;
			FN_READ: begin
				case (req.chunk_kind)
					KD_PTR:  cls.op = OP_RD_PTR;
					KD_128:  cls.op = OP_RD_128;
					KD_512:  cls.op = OP_RD_512;
					KD_2K:   cls.op = OP_RD_2K;
					default: cls.op = OP_RD_BAD;
				endcase
			end
			default: cls.op = OP_NOP;
		endcase
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/ccd_back.sv]
// Back end: executes classified commands against the control table memory,
// keeps the open-write and read-hint state and drives the result register.
// Depends on ccd_pkg and the assertion macro header.
`include "chained_chunk_cache_directory_assert.svh"

module ccd_back import ccd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]       st_q;
	cmd_t             c_q;
	logic [ENT_W-1:0] ent_q;
	logic [11:0]      cnt_q;
	logic             sok_q;
	logic             ph_q;
	logic [2:0]       owm_q;
	logic [ENT_W-1:0] owe_q;
	logic [15:0]      owo_q;
	logic             hv_q;
	logic [ENT_W-1:0] ho_q;
	logic [ENT_W-1:0] he_q;
	logic [11:0]      hi_q;
	logic [39:0]      mem_q [CHUNK_COUNT];
	logic [39:0]      mrd_q;
	rsp_t             res_q;
	logic             res_valid_q;

	logic [ENT_W-1:0] ent_sel;
	logic [11:0]      cnt_sel;
	logic             sok_sel;
	logic             clr_hint;
	logic             hit_same;
	logic             hit_next;
	logic [7:0]       b0;
	logic [15:0]      wrd;
	logic             mem_we;
	logic [39:0]      mem_wd;
	logic             done;
	rsp_t             r;
	logic [2:0]       m_nxt;
	logic             m_upd;
	logic             e_upd;
	logic             o_upd;
	logic             h_upd;
	logic [15:0]      sb_m1;
	logic [39:0]      tmp;

	// Writes a 512-byte object's size into its slot byte and large flag.
	function automatic logic [39:0] put_small(input logic [39:0] w, input logic [1:0] slot,
		input logic [9:0] s);
		logic [39:0] v;
		logic [7:0]  m1;
		logic        big;
		v   = w;
		m1  = 8'(s - 10'd1);
		big = (s > 10'd256);
		case (slot)
			2'd0: begin
				v[15:8] = m1;
				v[4]    = big;
			end
			2'd1: begin
				v[23:16] = m1;
				v[5]     = big;
			end
			2'd2: begin
				v[31:24] = m1;
				v[6]     = big;
			end
			default: begin
				v[39:32] = m1;
				v[7]     = big;
			end
		endcase
		return v;
	endfunction

	// Size of a chain chunk: set only on the last chunk of a chain.
	function automatic logic [11:0] final_size(input logic [39:0] w, input logic single_ok);
		logic [11:0] s;
		s = 12'd0;
		if (w[7:0] == {5'd0, TY_END} || (single_ok && w[7:0] == {5'd0, TY_SINGLE})) begin
			s = w[19:8] + 12'd1;
		end
		return s;
	endfunction

	assign pop       = (st_q == ST_IDLE) && cmd_valid && !(res_valid_q && rsp_stall);
	assign rsp_valid = res_valid_q;
	assign rsp       = res_q;
	assign b0        = mrd_q[7:0];
	assign wrd       = mrd_q[23:8];
	assign sb_m1     = {4'd0, c_q.size_big - 12'd1};

	// Pick the first entry to read and the length of any chain walk.
	always_comb begin
		hit_same = hv_q && (ho_q == cmd.obj[ENT_W-1:0]) && (cmd.cidx == hi_q);
		hit_next = hv_q && (ho_q == cmd.obj[ENT_W-1:0])
			&& ({1'b0, cmd.cidx} == {1'b0, hi_q} + 13'd1);
		cnt_sel  = 12'd0;
		sok_sel  = 1'b1;
		clr_hint = 1'b0;
		case (cmd.op)
			OP_WR_128, OP_RD_128: ent_sel = cmd.obj[15:4];
			OP_WR_512, OP_RD_512: ent_sel = cmd.obj[13:2];
			OP_WR_2K: begin
				ent_sel = (owm_q == TY_SINGLE || owm_q == TY_MIDDLE)
					? owe_q : cmd.obj[ENT_W-1:0];
			end
			OP_FIN: ent_sel = owe_q;
			OP_RD_2K: begin
				if (hit_same) begin
					ent_sel = he_q;
				end else if (hit_next) begin
					ent_sel = he_q;
					cnt_sel = 12'd1;
					sok_sel = 1'b0;
				end else begin
					ent_sel = cmd.obj[ENT_W-1:0];
					cnt_sel = cmd.cidx;
				end
			end
			default: ent_sel = '0;
		endcase
		if (cmd.op inside {OP_WR_BAD, OP_WR_PTR, OP_WR_128, OP_WR_512, OP_WR_2K,
			OP_RD_PTR, OP_RD_128, OP_RD_512, OP_RD_BAD}) begin
			clr_hint = 1'b1;
		end
	end

	// Execute the command on the entry just read.
	always_comb begin
		mem_we = 1'b0;
		mem_wd = mrd_q;
		done   = 1'b1;
		r      = '0;
		m_nxt  = owm_q;
		m_upd  = 1'b0;
		e_upd  = 1'b0;
		o_upd  = 1'b0;
		h_upd  = 1'b0;
		tmp    = mrd_q;
		case (c_q.op)
			OP_WR_PTR, OP_WR_128: begin
				mem_we    = 1'b1;
				mem_wd    = {mrd_q[39:8], 5'd0, TY_RANDOM};
				m_nxt     = TY_RANDOM;
				m_upd     = 1'b1;
				e_upd     = 1'b1;
				o_upd     = 1'b1;
				r.ok      = 1'b1;
				r.address = (c_q.op == OP_WR_PTR) ? {c_q.obj[14:0], 8'd0} : {c_q.obj, 7'd0};
			end
			OP_WR_512: begin
				tmp       = {mrd_q[39:8], (b0 & 8'hF0) | {5'd0, TY_SMALL}};
				mem_we    = 1'b1;
				mem_wd    = put_small(tmp, c_q.obj[1:0], c_q.size_sm);
				m_nxt     = TY_SMALL;
				m_upd     = 1'b1;
				e_upd     = 1'b1;
				o_upd     = 1'b1;
				r.ok      = 1'b1;
				r.address = {c_q.obj[13:0], 9'd0};
			end
			OP_WR_2K: begin
				if (ph_q) begin
					// Second half of a chain link: the newly linked chunk.
					mem_we = 1'b1;
					if (c_q.size_big == 12'd0) begin
						mem_wd = {mrd_q[39:24], 16'd0, 5'd0, TY_MIDDLE};
						m_nxt  = TY_MIDDLE;
					end else begin
						mem_wd = {mrd_q[39:24], sb_m1, 5'd0, TY_END};
						m_nxt  = TY_END;
					end
					m_upd     = 1'b1;
					e_upd     = 1'b1;
					r.ok      = 1'b1;
					r.address = {c_q.chain, 11'd0};
				end else if (owm_q != TY_SINGLE && owm_q != TY_MIDDLE) begin
					mem_we = 1'b1;
					mem_wd = {mrd_q[39:24], (c_q.size_big != 12'd0) ? sb_m1 : 16'd0,
						5'd0, TY_SINGLE};
					m_nxt     = TY_SINGLE;
					m_upd     = 1'b1;
					e_upd     = 1'b1;
					o_upd     = 1'b1;
					r.ok      = 1'b1;
					r.address = {c_q.chain, 11'd0};
				end else if (wrd == 16'd0) begin
					// Link the open chunk to the chain chunk, then visit that one.
					mem_we = 1'b1;
					mem_wd = {mrd_q[39:24], {4'd0, c_q.chain},
						(owm_q == TY_SINGLE) ? {5'd0, TY_BEGIN} : b0};
					done   = 1'b0;
				end
			end
			OP_FIN: begin
				m_nxt = TY_NONE;
				m_upd = 1'b1;
				case (owm_q)
					TY_RANDOM: r.ok = 1'b1;
					TY_SMALL: begin
						mem_we = c_q.size_nz;
						mem_wd = put_small(mrd_q, owo_q[1:0], c_q.size_sm);
						r.ok   = 1'b1;
					end
					TY_MIDDLE: begin
						mem_we = 1'b1;
						mem_wd = {mrd_q[39:24], c_q.size_nz ? sb_m1 : wrd, 5'd0, TY_END};
						r.ok   = 1'b1;
					end
					TY_SINGLE, TY_END: begin
						mem_we = c_q.size_nz;
						mem_wd = {mrd_q[39:24], sb_m1, b0};
						r.ok   = 1'b1;
					end
					default: r.ok = 1'b0;
				endcase
			end
			OP_RD_PTR: begin
				r.ok      = 1'b1;
				r.address = {c_q.obj[14:0], 8'd0};
			end
			OP_RD_128: begin
				if (b0 == {5'd0, TY_RANDOM}) begin
					r.ok      = 1'b1;
					r.address = {c_q.obj, 7'd0};
				end
			end
			OP_RD_512: begin
				if (b0[3:0] == {1'b0, TY_SMALL}) begin
					r.ok      = 1'b1;
					r.address = {c_q.obj[13:0], 9'd0};
					case (c_q.obj[1:0])
						2'd0: r.size_out = {3'd0, b0[4], mrd_q[15:8]} + 12'd1;
						2'd1: r.size_out = {3'd0, b0[5], mrd_q[23:16]} + 12'd1;
						2'd2: r.size_out = {3'd0, b0[6], mrd_q[31:24]} + 12'd1;
						default: r.size_out = {3'd0, b0[7], mrd_q[39:32]} + 12'd1;
					endcase
				end
			end
			OP_RD_2K: begin
				if (cnt_q != 12'd0) begin
					done = 1'b0;
				end else begin
					h_upd      = 1'b1;
					r.ok       = 1'b1;
					r.size_out = final_size(mrd_q, sok_q);
					r.address  = {ent_q, 11'd0};
				end
			end
			default: r.ok = 1'b0;
		endcase
		if (st_q != ST_EXEC) begin
			mem_we = 1'b0;
		end
	end

	// Control table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[ent_q] <= mem_wd;
		end
		mrd_q <= mem_q[ent_q];
	end

	// Command registers carry payload only.
	always_ff @(posedge clk) begin
		if (pop) begin
			c_q <= cmd;
		end
	end

	// Sequencer, directory state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ent_q       <= '0;
			cnt_q       <= 12'd0;
			sok_q       <= 1'b0;
			ph_q        <= 1'b0;
			owm_q       <= TY_NONE;
			owe_q       <= '0;
			owo_q       <= 16'd0;
			hv_q        <= 1'b0;
			ho_q        <= '0;
			he_q        <= '0;
			hi_q        <= 12'd0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !rsp_stall) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						ent_q <= ent_sel;
						cnt_q <= cnt_sel;
						sok_q <= sok_sel;
						ph_q  <= 1'b0;
						st_q  <= ST_WAIT;
						if (clr_hint) begin
							hv_q <= 1'b0;
						end
					end
				end
				ST_WAIT: st_q <= ST_EXEC;
				ST_EXEC: begin
					if (done) begin
						res_q       <= r;
						res_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
						if (m_upd) begin
							owm_q <= m_nxt;
						end
						if (e_upd) begin
							owe_q <= ent_q;
						end
						if (o_upd) begin
							owo_q <= c_q.obj;
						end
						if (h_upd) begin
							hv_q <= 1'b1;
							ho_q <= c_q.obj[ENT_W-1:0];
							hi_q <= c_q.cidx;
							he_q <= ent_q;
						end
					end else begin
						st_q <= ST_WAIT;
						if (c_q.op == OP_RD_2K) begin
							ent_q <= wrd[ENT_W-1:0];
							cnt_q <= cnt_q - 12'd1;
						end else begin
							ent_q <= c_q.chain;
							ph_q  <= 1'b1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`CCD_ASSERT(a_pop_idle, pop, st_q == ST_IDLE && !(res_valid_q && rsp_stall), "pop outside idle")
	`CCD_ASSERT(a_we_exec, mem_we, st_q == ST_EXEC, "table write outside execute")
	`CCD_ASSERT_NEXT(a_wait_exec, st_q == ST_WAIT, st_q == ST_EXEC, "wait not followed by execute")
	`CCD_ASSERT_NEXT(a_result, st_q == ST_EXEC && done, res_valid_q, "finished command lost")

endmodule

[sv/chained_chunk_cache_directory.sv]
// Chained chunk cache directory: request beats in on req, one result beat
// out on rsp for every request, in order.
// Both channels use valid and stall; a beat moves on a rising edge with
// valid high and stall low. req carries func, chunk_kind, object_id,
// size, link_chunk and chain_pos; rsp carries address, size_out, ok.
// A two-entry queue sits behind req, so requests are taken while the back
// end works and while a finished result waits in the output register.
// Each request costs one control-table access (address, registered read,
// execute and write-back); the back end takes a new request only once
// it has finished the last. A 2 KiB write that links a chain costs two
// accesses, and a 2 KiB read that walks n links costs one more access
// per link; a read at the hinted chain index or the next one walks at
// most one link.
// While rsp is stalled the result register holds its beat and the back end
// starts no new request; req stalls once the queue is full.
// Reset clears the queue, open write and read hint; the control table is
// not cleared and must be written before it is read.
// Depends on ccd_pkg, ccd_front and ccd_back.
module chained_chunk_cache_directory import ccd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic cmd_valid;
	cmd_t cmd;
	logic pop;

	// Classification and queueing.
	ccd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop)
	);

	// Table access and results.
	ccd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
